@@ sv/lru_key_cache_top_assert.svh @@
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef LRU_KEY_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_CACHE_TOP_ASSERT_SVH

// same-cycle implication
`define LKC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru_key_cache: same-cycle check failed");

// next-cycle implication
`define LKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru_key_cache: next-cycle check failed");

`endif

@@ sv/lkc_pkg.sv @@
`timescale 1ns / 1ps

package lkc_pkg;

    localparam int ENTRIES   = 4;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = $clog2(ENTRIES);
    localparam int RANK_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS  = 3;

    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CNT_BITS-1:0] CAP_RESET = 3'd4;

    localparam logic [2:0] ST_ACC_HIT  = 3'd0;
    localparam logic [2:0] ST_ACC_MISS = 3'd1;
    localparam logic [2:0] ST_INS_HIT  = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_EVICTED  = 3'd4;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [RANK_BITS-1:0] t_rank;

    typedef struct packed {
        logic                action;
        logic [KEY_BITS-1:0] key;
    } t_lkc_in;

    typedef struct packed {
        logic [2:0]          status;
        logic [KEY_BITS-1:0] evicted_key;
        logic [CNT_BITS-1:0] occupancy;
    } t_lkc_out;

endpackage

@@ sv/lkc_regs.sv @@
`timescale 1ns / 1ps

module lkc_regs
    import lkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output logic [CNT_BITS-1:0]  o_eff_cap
);

    logic [CNT_BITS-1:0] r_capacity;
    logic                wr_cap;

    assign pready = 1'b1;
    assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (wr_cap) begin
            r_capacity <= pwdata[CNT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = DATA_BITS'(r_capacity);
        end
    end

    // zero acts as one, anything above the entry count saturates
    always_comb begin
        if (r_capacity == '0) begin
            o_eff_cap = CNT_BITS'(1);
        end else if (r_capacity > CNT_BITS'(ENTRIES)) begin
            o_eff_cap = CNT_BITS'(ENTRIES);
        end else begin
            o_eff_cap = r_capacity;
        end
    end

endmodule

@@ sv/lkc_core.sv @@
`timescale 1ns / 1ps

module lkc_core
    import lkc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  t_lkc_in             i_req,
    input  logic [CNT_BITS-1:0] i_eff_cap,
    output t_lkc_out            o_rsp
);

    logic [KEY_BITS-1:0] r_key [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    t_rank               r_rank [ENTRIES];
    logic [CNT_BITS-1:0] r_count;

    logic [KEY_BITS-1:0] n_key [ENTRIES];
    logic [ENTRIES-1:0]  n_valid;
    t_rank               n_rank [ENTRIES];
    logic [CNT_BITS-1:0] n_count;

    always_comb begin
        logic                hit, free_any, vic_any, upd, wr;
        t_slot               hit_idx, free_idx, vic_idx, p_idx;
        t_rank               hit_rank, vic_rank;
        logic [CNT_BITS-1:0] p_thr;
        logic [KEY_BITS-1:0] vic_key, evicted;
        logic [2:0]          status;

        hit = 1'b0; free_any = 1'b0; vic_any = 1'b0;
        hit_idx = '0; free_idx = '0; vic_idx = '0;
        hit_rank = '0; vic_rank = '0; vic_key = '0;
        upd = 1'b0; wr = 1'b0; p_idx = '0; p_thr = '0;
        evicted = '0;
        status = ST_ACC_MISS;
        n_key = r_key;
        n_valid = r_valid;
        n_rank = r_rank;
        n_count = r_count;

        // walk downward so the lowest matching slot wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_req.key)) begin
                hit = 1'b1;
                hit_idx = SLOT_BITS'(i);
                hit_rank = r_rank[i];
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_BITS'(i);
            end
            // least recent entry carries rank count-1
            if (r_valid[i] && (CNT_BITS'(r_rank[i]) == r_count - CNT_BITS'(1))) begin
                vic_any = 1'b1;
                vic_idx = SLOT_BITS'(i);
                vic_rank = r_rank[i];
                vic_key = r_key[i];
            end
        end

        if (hit) begin
            status = i_req.action ? ST_INS_HIT : ST_ACC_HIT;
            upd = 1'b1;
            p_idx = hit_idx;
            p_thr = CNT_BITS'(hit_rank);
        end else if (!i_req.action) begin
            status = ST_ACC_MISS;
        end else if (r_count < i_eff_cap) begin
            status = ST_INSERTED;
            if (free_any) begin
                // every valid entry ages by one
                upd = 1'b1;
                wr = 1'b1;
                p_idx = free_idx;
                p_thr = r_count;
                n_valid[free_idx] = 1'b1;
                n_count = r_count + CNT_BITS'(1);
            end
        end else if (vic_any) begin
            status = ST_EVICTED;
            evicted = vic_key;
            upd = 1'b1;
            wr = 1'b1;
            p_idx = vic_idx;
            p_thr = CNT_BITS'(vic_rank);
        end else begin
            status = ST_INSERTED;
        end

        if (upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (SLOT_BITS'(i) == p_idx) begin
                    n_rank[i] = '0;
                    if (wr) begin
                        n_key[i] = i_req.key;
                    end
                end else if (r_valid[i] && (CNT_BITS'(r_rank[i]) < p_thr)) begin
                    n_rank[i] = r_rank[i] + RANK_BITS'(1);
                end
            end
        end

        o_rsp.status = status;
        o_rsp.evicted_key = evicted;
        o_rsp.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_go) begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_key <= n_key;
        end
    end

`include "lru_key_cache_top_assert.svh"

    `LKC_ASSERT_IMP(a_count_matches_valid, 1'b1, $countones(r_valid) == 32'(r_count))
    `LKC_ASSERT_NEXT(a_miss_keeps_state, i_go && (o_rsp.status == ST_ACC_MISS),
        $stable(r_valid) && $stable(r_count))
    `LKC_ASSERT_NEXT(a_evict_keeps_count, i_go && (o_rsp.status == ST_EVICTED),
        $stable(r_count) && $stable(r_valid))

endmodule

@@ sv/lru_key_cache_top.sv @@
`timescale 1ns / 1ps
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------------
// request  | i_in_valid  | o_in_stall  | i_in_data  (action, key)
// result   | o_out_valid | i_out_stall | o_out_data (status, evicted_key, occupancy)
// config   | psel/penable/pwrite, pready tied high, capacity at byte address 0
//
// one request per cycle unless the result stalls; results leave through the lookup and result registers
// the rate is set by the single lookup stage: four key compares and the rank update
// reset is synchronous: clears valid bits, ranks and occupancy, capacity returns to 4
// a stalled result holds the lookup stage, which then stalls the request side

module lru_key_cache_top
    import lkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_lkc_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_lkc_out             o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic                r_s1_valid, n_s1_valid;
    t_lkc_in             r_s1_data;
    logic                r_out_valid, n_out_valid;
    t_lkc_out            r_out_data;
    logic                go, accept_in;
    logic [CNT_BITS-1:0] eff_cap;
    t_lkc_out            rsp;

    lkc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_cap (eff_cap)
    );

    lkc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_req     (r_s1_data),
        .i_eff_cap (eff_cap),
        .o_rsp     (rsp)
    );

    // the lookup stage moves on when the result register is free or draining
    assign go = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !go;
    assign accept_in = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept_in) begin
            n_s1_valid = 1'b1;
        end else if (go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (go) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_data <= i_in_data;
        end
        if (go) begin
            r_out_data <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

`include "lru_key_cache_top_assert.svh"

    `LKC_ASSERT_IMP(a_stall_only_when_busy, o_in_stall, r_s1_valid && r_out_valid)
    `LKC_ASSERT_NEXT(a_go_fills_result, go, r_out_valid)
    `LKC_ASSERT_NEXT(a_stalled_result_holds, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data))

endmodule
